// ===== rtl/mmes_pkg.sv =====
// Shared constants, codes and types of the min/max extract store.
// No dependencies; every other file imports this package.
`default_nettype none
package mmes_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 64;

    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_EXT_MIN = 2'd1;
    localparam logic [1:0] MODE_EXT_MAX = 2'd2;
    localparam logic [1:0] MODE_COMBINE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_TOO_FEW = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [VAL_W-1:0] wr_data;
        logic             clr_en;
        logic [IDX_W-1:0] clr_addr;
    } t_store_cmd;

endpackage
`default_nettype wire

// ===== rtl/mmes_if.sv =====
// Valid/ready channels of the min/max extract store: operation in, result out.
// Depends on mmes_pkg for field widths.
`default_nettype none
interface mmes_in_if;
    import mmes_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       mode;
    logic [VAL_W-1:0] value;
    modport source (output valid, mode, value, input ready);
    modport sink (input valid, mode, value, output ready);
endinterface

interface mmes_out_if;
    import mmes_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [VAL_W-1:0] low_value;
    logic [VAL_W-1:0] high_value;
    logic [VAL_W-1:0] sum_value;
    logic             sum_carry;
    logic [6:0]       entry_count;
    modport source (output valid, status, low_value, high_value, sum_value, sum_carry,
                    entry_count, input ready);
    modport sink (input valid, status, low_value, high_value, sum_value, sum_carry,
                  entry_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/mmes_store.sv =====
// Value memory with one write and one registered read port, plus per-slot valid bits.
// Depends on mmes_pkg.
`default_nettype none
module mmes_store
    import mmes_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_store_cmd          i_cmd,
    output logic [VAL_W-1:0]         o_rd_data,
    output logic                     o_rd_valid,
    output logic [CAPACITY-1:0]      o_valid
);

    logic [VAL_W-1:0]    r_mem [CAPACITY];
    logic [CAPACITY-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        o_rd_data <= r_mem[i_cmd.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            o_rd_valid <= 1'b0;
        end else begin
            o_rd_valid <= r_valid[i_cmd.rd_addr];
            if (i_cmd.wr_en) begin
                r_valid[i_cmd.wr_addr] <= 1'b1;
            end
            if (i_cmd.clr_en) begin
                r_valid[i_cmd.clr_addr] <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;

endmodule
`default_nettype wire

// ===== rtl/mmes_seq.sv =====
// Sequencer: one shared 64-bit comparator scans the store, plus the result register.
// Depends on mmes_pkg and mmes_if.
`default_nettype none
module mmes_seq
    import mmes_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    mmes_in_if.sink              i_item,
    mmes_out_if.source           o_res,
    output t_store_cmd           o_cmd,
    input  wire logic [VAL_W-1:0] i_rd_data,
    input  wire logic            i_rd_valid,
    input  wire logic [CAPACITY-1:0] i_valid
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FREE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_TAKE  = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    logic [2:0]       r_state;
    logic [1:0]       r_mode;
    logic [VAL_W-1:0] r_value;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_didx;
    logic             r_dv;
    logic             r_want_max;
    logic             r_pass2;
    logic             r_found;
    logic [IDX_W-1:0] r_pick;
    logic [VAL_W-1:0] r_best;
    logic             r_free_ok;
    logic [IDX_W-1:0] r_free;
    logic [1:0]       r_status;
    logic [VAL_W-1:0] r_low;
    logic [VAL_W-1:0] r_high;
    logic [VAL_W-1:0] r_sum;
    logic             r_carry;

    logic             r_ovld;
    logic [1:0]       r_o_status;
    logic [VAL_W-1:0] r_o_low;
    logic [VAL_W-1:0] r_o_high;
    logic [VAL_W-1:0] r_o_sum;
    logic             r_o_carry;
    logic [6:0]       r_o_count;

    logic             in_xfer;
    logic             out_free;
    logic             better;
    logic [VAL_W:0]   sum_full;
    logic [IDX_W-1:0] put_slot;
    logic [1:0]       start_status;

    assign in_xfer  = i_item.valid && i_item.ready;
    assign out_free = !r_ovld || o_res.ready;
    assign i_item.ready = (r_state == S_IDLE);

    assign better   = r_want_max ? (i_rd_data > r_best) : (i_rd_data < r_best);
    assign sum_full = {1'b0, r_low} + {1'b0, r_best};
    assign put_slot = (r_free_ok && (r_free < r_pick)) ? r_free : r_pick;

    always_comb begin
        start_status = ST_OK;
        unique case (i_item.mode)
            MODE_INSERT:  if (r_count >= FULL_CNT) start_status = ST_FULL;
            MODE_COMBINE: if (r_count < CNT_W'(2)) start_status = ST_TOO_FEW;
            default:      if (r_count == '0) start_status = ST_EMPTY;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.rd_addr  = r_idx;
        o_cmd.wr_addr  = r_idx;
        o_cmd.wr_data  = r_value;
        o_cmd.clr_addr = r_pick;
        unique case (r_state)
            S_FREE: begin
                o_cmd.wr_en = !i_valid[r_idx];
            end
            S_TAKE: begin
                o_cmd.clr_en = 1'b1;
            end
            S_PUT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = put_slot;
                o_cmd.wr_data = r_sum;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_dv) begin
            if (i_rd_valid) begin
                if (!r_found || better) begin
                    r_pick  <= r_didx;
                    r_best  <= i_rd_data;
                    r_found <= 1'b1;
                end
            end else if (!r_free_ok || (r_didx < r_free)) begin
                r_free    <= r_didx;
                r_free_ok <= 1'b1;
            end
        end
        unique case (r_state)
            S_IDLE: begin
                r_mode     <= i_item.mode;
                r_value    <= i_item.value;
                r_idx      <= '0;
                r_found    <= 1'b0;
                r_free_ok  <= 1'b0;
                r_pass2    <= 1'b0;
                r_want_max <= (i_item.mode == MODE_EXT_MAX);
                r_status   <= start_status;
                r_low      <= '0;
                r_high     <= '0;
                r_sum      <= '0;
                r_carry    <= 1'b0;
            end
            S_FREE: begin
                r_idx <= r_idx + IDX_W'(1);
            end
            S_SCAN: begin
                r_didx <= r_idx;
                if (r_idx != LAST_IDX) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            S_TAKE: begin
                if (r_mode == MODE_COMBINE && !r_pass2) begin
                    r_low      <= r_best;
                    r_pass2    <= 1'b1;
                    r_want_max <= 1'b1;
                    r_found    <= 1'b0;
                    r_idx      <= '0;
                end else if (r_mode == MODE_COMBINE) begin
                    r_high  <= r_best;
                    r_sum   <= sum_full[VAL_W-1:0];
                    r_carry <= sum_full[VAL_W];
                end else begin
                    r_low <= r_best;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_dv    <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_dv   <= (r_state == S_SCAN);
            r_ovld <= (r_state == S_DONE && out_free) || (r_ovld && !o_res.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        unique case (i_item.mode)
                            MODE_INSERT:
                                r_state <= (r_count >= FULL_CNT) ? S_DONE : S_FREE;
                            MODE_COMBINE:
                                r_state <= (r_count < CNT_W'(2)) ? S_DONE : S_SCAN;
                            default:
                                r_state <= (r_count == '0) ? S_DONE : S_SCAN;
                        endcase
                    end
                end
                S_FREE: begin
                    if (!i_valid[r_idx]) begin
                        r_count <= r_count + CNT_W'(1);
                        r_state <= S_DONE;
                    end
                end
                S_SCAN: begin
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_TAKE;
                end
                S_TAKE: begin
                    r_count <= r_count - CNT_W'(1);
                    if (r_mode == MODE_COMBINE) begin
                        r_state <= r_pass2 ? S_PUT : S_SCAN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_PUT: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_o_status <= r_status;
            r_o_low    <= r_low;
            r_o_high   <= r_high;
            r_o_sum    <= r_sum;
            r_o_carry  <= r_carry;
            r_o_count  <= 7'(r_count);
        end
    end

    assign o_res.valid       = r_ovld;
    assign o_res.status      = r_o_status;
    assign o_res.low_value   = r_o_low;
    assign o_res.high_value  = r_o_high;
    assign o_res.sum_value   = r_o_sum;
    assign o_res.sum_carry   = r_o_carry;
    assign o_res.entry_count = r_o_count;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("stored count above capacity");

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (32'(r_count) == 32'($countones(i_valid))))
        else $error("stored count disagrees with valid bits");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == ST_FULL) |-> (r_count == FULL_CNT))
        else $error("full reported on a store with room");

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAKE) |-> (r_found && i_valid[r_pick]))
        else $error("removing a slot that holds no value");

endmodule
`default_nettype wire

// ===== rtl/min_max_extract_store_top.sv =====
// Top level of the min/max extract store: operation channel in, result channel out.
// Depends on mmes_pkg, mmes_if, mmes_store and mmes_seq.
//
// Usage:
//   i_item carries one operation per transfer: mode (insert, extract minimum,
//   extract maximum, combine) and a 64-bit value used only by insert.
//   o_res returns exactly one result per operation: status, extracted values,
//   combine sum with carry, and the entry count after the operation.
//   The block handles one operation at a time; i_item.ready is high only
//   while the sequencer is idle.
//   Steps per operation, from input transfer to result valid:
//     rejected operation (full, empty, too few): straight to the result
//     insert: scan from slot 0 up to the lowest free slot, then write there
//     extract: a sequential scan through the single read port, then removal
//     combine: two scans on the shared comparator plus the sum write
//   Reset empties the store (valid bits cleared, count zero) and drops any
//   pending result; no clearing pass is needed.
//   A stalled receiver holds the result in the output register; the next
//   operation is accepted meanwhile, but its result waits until that register
//   is free.
`default_nettype none
module min_max_extract_store_top
    import mmes_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mmes_in_if.sink    i_item,
    mmes_out_if.source o_res
);

    t_store_cmd          cmd;
    logic [VAL_W-1:0]    rd_data;
    logic                rd_valid;
    logic [CAPACITY-1:0] valid_bits;

    mmes_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_rd_data  (rd_data),
        .o_rd_valid (rd_valid),
        .o_valid    (valid_bits)
    );

    mmes_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .o_res      (o_res),
        .o_cmd      (cmd),
        .i_rd_data  (rd_data),
        .i_rd_valid (rd_valid),
        .i_valid    (valid_bits)
    );

endmodule
`default_nettype wire
